[src/r2q_pkg.sv]
// Shared types and constants for the rotation matrix to quaternion core.
// No dependencies; imported by every module of the core.
`default_nettype none

package r2q_pkg;

   localparam int FIELD_W = 18;
   localparam int NUM_W   = 19;
   localparam int QUO_W   = 19;
   localparam int LANES   = 3;

   localparam logic signed [FIELD_W-1:0] OUT_MAX = 18'sh1FFFF;
   localparam logic signed [FIELD_W-1:0] OUT_MIN = 18'sh20000;

   localparam logic [1:0] CASE_TRACE = 2'd0;
   localparam logic [1:0] CASE_X     = 2'd1;
   localparam logic [1:0] CASE_Y     = 2'd2;
   localparam logic [1:0] CASE_Z     = 2'd3;

   // Control that travels alongside each item through the pipeline.
   typedef struct packed {
      logic       vld;
      logic [1:0] sel;
      logic       deg;
   } r2q_tag_type;

endpackage

`default_nettype wire

[src/r2q_front.sv]
// Branch selection, radicand and numerator formation: the first pipeline cell.
// Depends on r2q_pkg.
`default_nettype none

module r2q_front
   import r2q_pkg::*;
#(
   parameter int FRAC_BITS = 16,
   parameter int RAD_W     = 21
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         en,
   input  wire                         vld_i,
   input  wire  signed [FIELD_W-1:0]   r00,
   input  wire  signed [FIELD_W-1:0]   r01,
   input  wire  signed [FIELD_W-1:0]   r02,
   input  wire  signed [FIELD_W-1:0]   r10,
   input  wire  signed [FIELD_W-1:0]   r11,
   input  wire  signed [FIELD_W-1:0]   r12,
   input  wire  signed [FIELD_W-1:0]   r20,
   input  wire  signed [FIELD_W-1:0]   r21,
   input  wire  signed [FIELD_W-1:0]   r22,
   output r2q_tag_type                 tag_o,
   output logic        [RAD_W-2:0]     rad_o,
   output logic [LANES-1:0][NUM_W-1:0] num_o
);

   logic signed [19:0]            sum_w;
   logic signed [RAD_W-1:0]       one_w;
   logic signed [RAD_W-1:0]       rad_w;
   logic        [1:0]             sel_w;
   logic                          deg_w;
   logic [LANES-1:0][NUM_W-1:0]   num_w;
   r2q_tag_type                   tag_ff;
   logic        [RAD_W-2:0]       rad_ff;
   logic [LANES-1:0][NUM_W-1:0]   num_ff;

   always_comb begin
      sum_w = 20'(r00) + 20'(r11) + 20'(r22);
      one_w = RAD_W'(1) << FRAC_BITS;
      if (sum_w > 0) begin
         sel_w    = CASE_TRACE;
         rad_w    = RAD_W'(sum_w) + one_w;
         num_w[0] = NUM_W'(r21) - NUM_W'(r12);
         num_w[1] = NUM_W'(r02) - NUM_W'(r20);
         num_w[2] = NUM_W'(r10) - NUM_W'(r01);
      end else if (r00 > r11 && r00 > r22) begin
         sel_w    = CASE_X;
         rad_w    = one_w + RAD_W'(r00) - RAD_W'(r11) - RAD_W'(r22);
         num_w[0] = NUM_W'(r21) - NUM_W'(r12);
         num_w[1] = NUM_W'(r01) + NUM_W'(r10);
         num_w[2] = NUM_W'(r02) + NUM_W'(r20);
      end else if (r11 > r22) begin
         sel_w    = CASE_Y;
         rad_w    = one_w + RAD_W'(r11) - RAD_W'(r00) - RAD_W'(r22);
         num_w[0] = NUM_W'(r02) - NUM_W'(r20);
         num_w[1] = NUM_W'(r01) + NUM_W'(r10);
         num_w[2] = NUM_W'(r12) + NUM_W'(r21);
      end else begin
         sel_w    = CASE_Z;
         rad_w    = one_w + RAD_W'(r22) - RAD_W'(r00) - RAD_W'(r11);
         num_w[0] = NUM_W'(r10) - NUM_W'(r01);
         num_w[1] = NUM_W'(r02) + NUM_W'(r20);
         num_w[2] = NUM_W'(r12) + NUM_W'(r21);
      end
      deg_w = rad_w[RAD_W-1] || (rad_w == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff.vld <= 1'b0;
      end else if (en) begin
         tag_ff.vld <= vld_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff.sel <= sel_w;
         tag_ff.deg <= deg_w;
         rad_ff     <= deg_w ? '0 : rad_w[RAD_W-2:0];
         num_ff     <= num_w;
      end
   end

   assign tag_o = tag_ff;
   assign rad_o = rad_ff;
   assign num_o = num_ff;

endmodule

`default_nettype wire

[src/r2q_sqrt_cell.sv]
// One square root digit cell: consumes two radicand bits per cycle while en is high.
// Depends on r2q_pkg.
`default_nettype none

module r2q_sqrt_cell
   import r2q_pkg::*;
#(
   parameter int ROOT_W = 18,
   parameter int PAY_W  = 57
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   en,
   input  r2q_tag_type           tag_i,
   input  wire  [2*ROOT_W-1:0]   x_i,
   input  wire  [ROOT_W+1:0]     rem_i,
   input  wire  [ROOT_W-1:0]     root_i,
   input  wire  [PAY_W-1:0]      pay_i,
   output r2q_tag_type           tag_o,
   output logic [2*ROOT_W-1:0]   x_o,
   output logic [ROOT_W+1:0]     rem_o,
   output logic [ROOT_W-1:0]     root_o,
   output logic [PAY_W-1:0]      pay_o
);

   logic [ROOT_W+3:0]   cat_w;
   logic [ROOT_W+3:0]   trial_w;
   logic [ROOT_W+3:0]   diff_w;
   logic                ge_w;
   r2q_tag_type         tag_ff;
   logic [2*ROOT_W-1:0] x_ff;
   logic [ROOT_W+1:0]   rem_ff;
   logic [ROOT_W-1:0]   root_ff;
   logic [PAY_W-1:0]    pay_ff;

   always_comb begin
      cat_w   = {rem_i, x_i[2*ROOT_W-1 -: 2]};
      trial_w = {2'b00, root_i, 2'b01};
      diff_w  = cat_w - trial_w;
      ge_w    = cat_w >= trial_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff.vld <= 1'b0;
      end else if (en) begin
         tag_ff.vld <= tag_i.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff.sel <= tag_i.sel;
         tag_ff.deg <= tag_i.deg;
         x_ff       <= x_i << 2;
         rem_ff     <= ge_w ? diff_w[ROOT_W+1:0] : cat_w[ROOT_W+1:0];
         root_ff    <= {root_i[ROOT_W-2:0], ge_w};
         pay_ff     <= pay_i;
      end
   end

   assign tag_o  = tag_ff;
   assign x_o    = x_ff;
   assign rem_o  = rem_ff;
   assign root_o = root_ff;
   assign pay_o  = pay_ff;

endmodule

`default_nettype wire

[src/r2q_div_cell.sv]
// One quotient bit cell of the three-lane restoring divider chain.
// Depends on r2q_pkg.
`default_nettype none

module r2q_div_cell
   import r2q_pkg::*;
#(
   parameter int DIV_W = 19,
   parameter int PAY_W = 24
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          en,
   input  r2q_tag_type                  tag_i,
   input  wire  [DIV_W-1:0]             d_i,
   input  wire  [LANES-1:0][DIV_W-1:0]  rem_i,
   input  wire  [LANES-1:0][QUO_W-1:0]  low_i,
   input  wire  [LANES-1:0][QUO_W-1:0]  quo_i,
   input  wire  [PAY_W-1:0]             pay_i,
   output r2q_tag_type                  tag_o,
   output logic [DIV_W-1:0]             d_o,
   output logic [LANES-1:0][DIV_W-1:0]  rem_o,
   output logic [LANES-1:0][QUO_W-1:0]  low_o,
   output logic [LANES-1:0][QUO_W-1:0]  quo_o,
   output logic [PAY_W-1:0]             pay_o
);

   logic [LANES-1:0][DIV_W:0]   t_w;
   logic [LANES-1:0][DIV_W:0]   diff_w;
   logic [LANES-1:0]            ge_w;
   r2q_tag_type                 tag_ff;
   logic [DIV_W-1:0]            d_ff;
   logic [LANES-1:0][DIV_W-1:0] rem_ff;
   logic [LANES-1:0][QUO_W-1:0] low_ff;
   logic [LANES-1:0][QUO_W-1:0] quo_ff;
   logic [PAY_W-1:0]            pay_ff;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         t_w[i]    = {rem_i[i], low_i[i][QUO_W-1]};
         diff_w[i] = t_w[i] - {1'b0, d_i};
         ge_w[i]   = t_w[i] >= {1'b0, d_i};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff.vld <= 1'b0;
      end else if (en) begin
         tag_ff.vld <= tag_i.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff.sel <= tag_i.sel;
         tag_ff.deg <= tag_i.deg;
         d_ff       <= d_i;
         pay_ff     <= pay_i;
         for (int i = 0; i < LANES; i++) begin
            rem_ff[i] <= ge_w[i] ? diff_w[i][DIV_W-1:0] : t_w[i][DIV_W-1:0];
            low_ff[i] <= low_i[i] << 1;
            quo_ff[i] <= {quo_i[i][QUO_W-2:0], ge_w[i]};
         end
      end
   end

   assign tag_o = tag_ff;
   assign d_o   = d_ff;
   assign rem_o = rem_ff;
   assign low_o = low_ff;
   assign quo_o = quo_ff;
   assign pay_o = pay_ff;

endmodule

`default_nettype wire

[src/rotation_matrix_to_quaternion_core.sv]
// Top level of the rotation matrix to quaternion core (four-branch trace method).
// Depends on r2q_pkg, r2q_front, r2q_sqrt_cell and r2q_div_cell.
//
// One matrix is taken and one quaternion leaves per clock, in order, unless stalled.
// The pipeline is one cell for branch selection, ROOT_W square
// root digit cells (ROOT_W = ceil((max(FRAC_BITS,19) + 1 + FRAC_BITS) / 2),
// 18 at the default), one cell for the divider set-up and overflow check,
// nineteen quotient bit cells and the output register. The
// whole chain advances together and holds while a waiting result is stalled.
`default_nettype none

module rotation_matrix_to_quaternion_core
   import r2q_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_stall,
   input  wire  signed [FIELD_W-1:0]  req_r00,
   input  wire  signed [FIELD_W-1:0]  req_r01,
   input  wire  signed [FIELD_W-1:0]  req_r02,
   input  wire  signed [FIELD_W-1:0]  req_r10,
   input  wire  signed [FIELD_W-1:0]  req_r11,
   input  wire  signed [FIELD_W-1:0]  req_r12,
   input  wire  signed [FIELD_W-1:0]  req_r20,
   input  wire  signed [FIELD_W-1:0]  req_r21,
   input  wire  signed [FIELD_W-1:0]  req_r22,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output logic signed [FIELD_W-1:0]  rsp_q_w,
   output logic signed [FIELD_W-1:0]  rsp_q_x,
   output logic signed [FIELD_W-1:0]  rsp_q_y,
   output logic signed [FIELD_W-1:0]  rsp_q_z,
   output logic        [1:0]          rsp_case_taken,
   output logic                       rsp_degenerate
);

   localparam int RAD_W  = ((FRAC_BITS > 19) ? FRAC_BITS : 19) + 2;
   localparam int X_W    = RAD_W - 1 + FRAC_BITS;
   localparam int ROOT_W = (X_W + 1) / 2;
   localparam int DIV_W  = ROOT_W + 1;
   localparam int D_W    = FRAC_BITS + NUM_W + 1;
   localparam int CMP_W  = ((FRAC_BITS > ROOT_W) ? FRAC_BITS : ROOT_W) + QUO_W + 3;
   localparam int SQ_PAY = LANES * NUM_W;
   localparam int DV_PAY = FIELD_W + 2 * LANES;

   logic                         en;
   r2q_tag_type                  f_tag;
   logic [RAD_W-2:0]             f_rad;
   logic [LANES-1:0][NUM_W-1:0]  f_num;

   r2q_tag_type                  sq_tag  [ROOT_W+1];
   logic [2*ROOT_W-1:0]          sq_x    [ROOT_W+1];
   logic [ROOT_W+1:0]            sq_rem  [ROOT_W+1];
   logic [ROOT_W-1:0]            sq_root [ROOT_W+1];
   logic [SQ_PAY-1:0]            sq_pay  [ROOT_W+1];

   r2q_tag_type                  dv_tag  [QUO_W+1];
   logic [DIV_W-1:0]             dv_d    [QUO_W+1];
   logic [LANES-1:0][DIV_W-1:0]  dv_rem  [QUO_W+1];
   logic [LANES-1:0][QUO_W-1:0]  dv_low  [QUO_W+1];
   logic [LANES-1:0][QUO_W-1:0]  dv_quo  [QUO_W+1];
   logic [DV_PAY-1:0]            dv_pay  [QUO_W+1];

   // Divider set-up stage.
   logic [LANES-1:0][NUM_W-1:0]  s_num;
   logic [LANES-1:0][NUM_W-1:0]  s_mag;
   logic [ROOT_W-1:0]            s_root;
   logic [ROOT_W-2:0]            s_half;
   logic [DIV_W-1:0]             s_d;
   logic [LANES-1:0][D_W-1:0]    s_dvd;
   logic [LANES-1:0][CMP_W-1:0]  s_top;
   logic [LANES-1:0]             s_neg;
   logic [LANES-1:0]             s_ovf;
   logic [LANES-1:0][DIV_W-1:0]  s_rem0;
   logic [LANES-1:0][QUO_W-1:0]  s_low0;
   logic [FIELD_W-1:0]           s_dom;
   r2q_tag_type                  p_tag_ff;
   logic [DIV_W-1:0]             p_d_ff;
   logic [LANES-1:0][DIV_W-1:0]  p_rem_ff;
   logic [LANES-1:0][QUO_W-1:0]  p_low_ff;
   logic [DV_PAY-1:0]            p_pay_ff;

   // Output stage.
   logic [FIELD_W-1:0]           o_dom;
   logic [LANES-1:0]             o_neg;
   logic [LANES-1:0]             o_ovf;
   logic [LANES-1:0][FIELD_W-1:0] o_lane;
   logic [FIELD_W-1:0]           o_w;
   logic [FIELD_W-1:0]           o_x;
   logic [FIELD_W-1:0]           o_y;
   logic [FIELD_W-1:0]           o_z;
   logic                         rsp_valid_ff;
   logic [FIELD_W-1:0]           q_w_ff;
   logic [FIELD_W-1:0]           q_x_ff;
   logic [FIELD_W-1:0]           q_y_ff;
   logic [FIELD_W-1:0]           q_z_ff;
   logic [1:0]                   case_ff;
   logic                         deg_ff;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   r2q_front #(
      .FRAC_BITS (FRAC_BITS),
      .RAD_W     (RAD_W)
   ) u_front (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .vld_i (req_valid),
      .r00   (req_r00),
      .r01   (req_r01),
      .r02   (req_r02),
      .r10   (req_r10),
      .r11   (req_r11),
      .r12   (req_r12),
      .r20   (req_r20),
      .r21   (req_r21),
      .r22   (req_r22),
      .tag_o (f_tag),
      .rad_o (f_rad),
      .num_o (f_num)
   );

   assign sq_tag[0]  = f_tag;
   assign sq_x[0]    = (2*ROOT_W)'(f_rad) << FRAC_BITS;
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;
   assign sq_pay[0]  = f_num;

   for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
      r2q_sqrt_cell #(
         .ROOT_W (ROOT_W),
         .PAY_W  (SQ_PAY)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .en     (en),
         .tag_i  (sq_tag[g]),
         .x_i    (sq_x[g]),
         .rem_i  (sq_rem[g]),
         .root_i (sq_root[g]),
         .pay_i  (sq_pay[g]),
         .tag_o  (sq_tag[g+1]),
         .x_o    (sq_x[g+1]),
         .rem_o  (sq_rem[g+1]),
         .root_o (sq_root[g+1]),
         .pay_o  (sq_pay[g+1])
      );
   end

   // The divisor is twice the root, and rounding to nearest is folded in by
   // dividing (|n| * one + root) by twice the root. A quotient that cannot fit
   // in nineteen bits is caught here and saturates later.
   always_comb begin
      s_num  = sq_pay[ROOT_W];
      s_root = sq_root[ROOT_W];
      s_half = s_root[ROOT_W-1:1];
      s_d    = {s_root, 1'b0};
      s_dom  = ((ROOT_W-1)'(OUT_MAX) < s_half) ? OUT_MAX : FIELD_W'(s_half);
      for (int i = 0; i < LANES; i++) begin
         s_neg[i]  = s_num[i][NUM_W-1];
         // The magnitude of the most negative numerator still fits unsigned.
         s_mag[i]  = s_neg[i] ? -s_num[i] : s_num[i];
         s_dvd[i]  = (D_W'(s_mag[i]) << FRAC_BITS) + D_W'(s_root);
         s_ovf[i]  = CMP_W'(s_dvd[i]) >= (CMP_W'(s_d) << QUO_W);
         s_top[i]  = CMP_W'(s_dvd[i]) >> QUO_W;
         s_rem0[i] = s_top[i][DIV_W-1:0];
         s_low0[i] = s_dvd[i][QUO_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_tag_ff.vld <= 1'b0;
      end else if (en) begin
         p_tag_ff.vld <= sq_tag[ROOT_W].vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_tag_ff.sel <= sq_tag[ROOT_W].sel;
         p_tag_ff.deg <= sq_tag[ROOT_W].deg;
         p_d_ff       <= s_d;
         p_rem_ff     <= s_rem0;
         p_low_ff     <= s_low0;
         p_pay_ff     <= {s_dom, s_neg, s_ovf};
      end
   end

   assign dv_tag[0] = p_tag_ff;
   assign dv_d[0]   = p_d_ff;
   assign dv_rem[0] = p_rem_ff;
   assign dv_low[0] = p_low_ff;
   assign dv_quo[0] = '0;
   assign dv_pay[0] = p_pay_ff;

   for (genvar g = 0; g < QUO_W; g++) begin : g_div
      r2q_div_cell #(
         .DIV_W (DIV_W),
         .PAY_W (DV_PAY)
      ) u_cell (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .tag_i (dv_tag[g]),
         .d_i   (dv_d[g]),
         .rem_i (dv_rem[g]),
         .low_i (dv_low[g]),
         .quo_i (dv_quo[g]),
         .pay_i (dv_pay[g]),
         .tag_o (dv_tag[g+1]),
         .d_o   (dv_d[g+1]),
         .rem_o (dv_rem[g+1]),
         .low_o (dv_low[g+1]),
         .quo_o (dv_quo[g+1]),
         .pay_o (dv_pay[g+1])
      );
   end

   // Apply the sign and saturate; a negative result may reach the minimum.
   always_comb begin
      {o_dom, o_neg, o_ovf} = dv_pay[QUO_W];
      for (int i = 0; i < LANES; i++) begin
         if (o_neg[i]) begin
            if (o_ovf[i] || dv_quo[QUO_W][i] > QUO_W'(131072)) begin
               o_lane[i] = OUT_MIN;
            end else begin
               o_lane[i] = FIELD_W'(-dv_quo[QUO_W][i]);
            end
         end else begin
            if (o_ovf[i] || dv_quo[QUO_W][i] > QUO_W'(OUT_MAX)) begin
               o_lane[i] = OUT_MAX;
            end else begin
               o_lane[i] = FIELD_W'(dv_quo[QUO_W][i]);
            end
         end
      end
      case (dv_tag[QUO_W].sel)
         CASE_TRACE: begin
            o_w = o_dom;     o_x = o_lane[0]; o_y = o_lane[1]; o_z = o_lane[2];
         end
         CASE_X: begin
            o_w = o_lane[0]; o_x = o_dom;     o_y = o_lane[1]; o_z = o_lane[2];
         end
         CASE_Y: begin
            o_w = o_lane[0]; o_x = o_lane[1]; o_y = o_dom;     o_z = o_lane[2];
         end
         default: begin
            o_w = o_lane[0]; o_x = o_lane[1]; o_y = o_lane[2]; o_z = o_dom;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_tag[QUO_W].vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_w_ff  <= dv_tag[QUO_W].deg ? '0 : o_w;
         q_x_ff  <= dv_tag[QUO_W].deg ? '0 : o_x;
         q_y_ff  <= dv_tag[QUO_W].deg ? '0 : o_y;
         q_z_ff  <= dv_tag[QUO_W].deg ? '0 : o_z;
         case_ff <= dv_tag[QUO_W].sel;
         deg_ff  <= dv_tag[QUO_W].deg;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_q_w        = q_w_ff;
   assign rsp_q_x        = q_x_ff;
   assign rsp_q_y        = q_y_ff;
   assign rsp_q_z        = q_z_ff;
   assign rsp_case_taken = case_ff;
   assign rsp_degenerate = deg_ff;

endmodule

`default_nettype wire

[src/r2q_checker.sv]
// Port-level checks for the rotation matrix to quaternion core, bound to the top.
// Depends on r2q_pkg and rotation_matrix_to_quaternion_core.
`default_nettype none

module r2q_checker
   import r2q_pkg::*;
(
   input wire                        clock,
   input wire                        reset,
   input wire                        req_stall,
   input wire                        rsp_valid,
   input wire                        rsp_stall,
   input wire signed [FIELD_W-1:0]   rsp_q_w,
   input wire signed [FIELD_W-1:0]   rsp_q_x,
   input wire signed [FIELD_W-1:0]   rsp_q_y,
   input wire signed [FIELD_W-1:0]   rsp_q_z,
   input wire        [1:0]           rsp_case_taken,
   input wire                        rsp_degenerate
);

   // A stalled result must not change until its transfer completes.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_q_w) && $stable(rsp_q_x)
         && $stable(rsp_q_y) && $stable(rsp_q_z) && $stable(rsp_case_taken)
         && $stable(rsp_degenerate))
      else $error("stalled result changed");

   // The input side only backs up behind a waiting result.
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a waiting result");

   a_deg_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_q_w == '0 && rsp_q_x == '0
         && rsp_q_y == '0 && rsp_q_z == '0)
      else $error("degenerate result is not zero");

   // The dominant component is a root and cannot be negative.
   a_dom_sign : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_degenerate |->
         (rsp_case_taken == CASE_TRACE && !rsp_q_w[FIELD_W-1])
         || (rsp_case_taken == CASE_X && !rsp_q_x[FIELD_W-1])
         || (rsp_case_taken == CASE_Y && !rsp_q_y[FIELD_W-1])
         || (rsp_case_taken == CASE_Z && !rsp_q_z[FIELD_W-1]))
      else $error("dominant component negative");

endmodule

bind rotation_matrix_to_quaternion_core r2q_checker u_r2q_checker (.*);

`default_nettype wire
